>>> hdl/slx_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the streaming token lexer.
package slx_pkg;

  localparam int MAX_LINE_LENGTH = 4096;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 12;
  localparam int LEN_W   = 12;
  localparam int CLASS_W = 3;
  localparam int KW_W    = 2;
  localparam int WORD_W  = 32;

  localparam int POS_CAP_I = ((MAX_LINE_LENGTH - 1) < 4095) ? (MAX_LINE_LENGTH - 1) : 4095;
  localparam int LEN_CAP_I = (MAX_LINE_LENGTH < 4095) ? MAX_LINE_LENGTH : 4095;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

  // queue between classifier and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_LESS    = 3'd3,
    MODE_GREATER = 3'd4
  } lex_mode_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_IDENT   = 3'd0,
    CLS_NUMBER  = 3'd1,
    CLS_OPER    = 3'd2,
    CLS_KEYWORD = 3'd3,
    CLS_PUNCT   = 3'd4
  } tok_class_t;

  typedef enum logic [KW_W-1:0] {
    KW_COUT = 2'd0,
    KW_CIN  = 2'd1,
    KW_ENDL = 2'd2,
    KW_NONE = 2'd3
  } kw_t;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  // first character in bits 7..0
  localparam logic [WORD_W-1:0] WORD_COUT = 32'h7475_6F63;
  localparam logic [WORD_W-1:0] WORD_CIN  = 32'h006E_6963;
  localparam logic [WORD_W-1:0] WORD_ENDL = 32'h6C64_6E65;

  typedef struct packed {
    tok_class_t        cls;
    kw_t               kw;
    logic [CHAR_W-1:0] sym;
    logic              dbl;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  // one or two tokens caused by one character
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } bundle_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

>>> hdl/slx_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters in and tokens out.
interface slx_char_if import slx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface slx_token_if import slx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] token_class;
  logic [KW_W-1:0]    keyword_index;
  logic [CHAR_W-1:0]  symbol_char;
  logic               doubled;
  logic [POS_W-1:0]   token_start;
  logic [LEN_W-1:0]   token_length;
  logic               last_of_run;

  modport source (output valid, output token_class, output keyword_index, output symbol_char,
                  output doubled, output token_start, output token_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_class, input keyword_index, input symbol_char,
                  input doubled, input token_start, input token_length,
                  input last_of_run, output ready);
endinterface

>>> hdl/slx_front.sv
`timescale 1ns / 1ps
// Classifier: consumes one character per cycle unless q_full, tracks the open token, pushes finished tokens.
module slx_front import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  slx_char_if.sink   chars,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  lex_mode_t         mode, mode_next;
  logic [WORD_W-1:0] word_prefix, word_prefix_next;
  logic [LEN_W-1:0]  open_length, open_length_next;
  logic [POS_W-1:0]  open_start, open_start_next;
  logic [POS_W-1:0]  line_position, line_position_next;

  logic              accept;
  logic [CHAR_W-1:0] c;
  logic              letter, digit, consumed;
  logic              ea, eb, ec;
  token_t            ta, tb, tc;

  function automatic token_t flush_tok(input lex_mode_t m, input logic [WORD_W-1:0] pfx,
                                       input logic [LEN_W-1:0] len,
                                       input logic [POS_W-1:0] st);
    token_t t;
    kw_t    kw;
    t.cls   = CLS_IDENT;
    t.kw    = KW_NONE;
    t.sym   = '0;
    t.dbl   = 1'b0;
    t.start = st;
    t.len   = len;
    t.last  = 1'b0;
    kw      = KW_NONE;
    unique case (m)
      MODE_IDENT: begin
        if (len == LEN_W'(4) && pfx == WORD_COUT) kw = KW_COUT;
        else if (len == LEN_W'(3) && pfx == WORD_CIN) kw = KW_CIN;
        else if (len == LEN_W'(4) && pfx == WORD_ENDL) kw = KW_ENDL;
        t.kw  = kw;
        t.cls = (kw == KW_NONE) ? CLS_IDENT : CLS_KEYWORD;
      end
      MODE_NUMBER: t.cls = CLS_NUMBER;
      MODE_LESS: begin
        t.cls = CLS_OPER;
        t.sym = CH_LT;
        t.len = LEN_W'(1);
      end
      MODE_GREATER: begin
        t.cls = CLS_OPER;
        t.sym = CH_GT;
        t.len = LEN_W'(1);
      end
      MODE_IDLE: t.cls = CLS_IDENT;
    endcase
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] ext_prefix(input logic [WORD_W-1:0] pfx,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [CHAR_W-1:0] ch);
    logic [WORD_W-1:0] r;
    r = pfx;
    if (len < LEN_W'(4)) begin
      case (len[1:0])
        2'd0:    r[7:0]   = ch;
        2'd1:    r[15:8]  = ch;
        2'd2:    r[23:16] = ch;
        default: r[31:24] = ch;
      endcase
    end
    return r;
  endfunction

  assign accept      = chars.valid && chars.ready;
  assign chars.ready = !q_full;
  assign c           = chars.char_code;
  assign letter      = is_letter(c);
  assign digit       = is_digit(c);

  // next state and the up to three candidate emissions of this character
  always_comb begin
    mode_next          = mode;
    word_prefix_next   = word_prefix;
    open_length_next   = open_length;
    open_start_next    = open_start;
    line_position_next = line_position;
    consumed           = 1'b0;
    ea                 = 1'b0;
    eb                 = 1'b0;
    ta                 = flush_tok(mode, word_prefix, open_length, open_start);
    tb.cls             = CLS_OPER;
    tb.kw              = KW_NONE;
    tb.sym             = c;
    tb.dbl             = 1'b0;
    tb.start           = line_position;
    tb.len             = LEN_W'(1);
    tb.last            = 1'b0;

    unique case (mode)
      MODE_IDENT, MODE_NUMBER: begin
        if (digit || (letter && mode == MODE_IDENT)) begin
          word_prefix_next = ext_prefix(word_prefix, open_length, c);
          open_length_next = (open_length < LEN_CAP) ? open_length + LEN_W'(1) : open_length;
          consumed         = 1'b1;
        end else begin
          ea               = 1'b1;
          mode_next        = MODE_IDLE;
          word_prefix_next = '0;
          open_length_next = '0;
        end
      end
      MODE_LESS, MODE_GREATER: begin
        ea               = 1'b1;
        mode_next        = MODE_IDLE;
        word_prefix_next = '0;
        open_length_next = '0;
        if (c == ((mode == MODE_LESS) ? CH_LT : CH_GT)) begin
          ta.dbl   = 1'b1;
          ta.len   = LEN_W'(2);
          consumed = 1'b1;
        end
      end
      MODE_IDLE: mode_next = MODE_IDLE;
    endcase

    if (!consumed) begin
      if (letter || digit) begin
        mode_next        = letter ? MODE_IDENT : MODE_NUMBER;
        open_start_next  = line_position;
        word_prefix_next = {{(WORD_W-CHAR_W){1'b0}}, c};
        open_length_next = LEN_W'(1);
      end else if (c == CH_LT || c == CH_GT) begin
        mode_next        = (c == CH_LT) ? MODE_LESS : MODE_GREATER;
        open_start_next  = line_position;
        word_prefix_next = '0;
        open_length_next = LEN_W'(1);
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
        eb = 1'b1;
      end else if (c == CH_SEMI || c == CH_COLON || c == CH_LBRACE || c == CH_RBRACE) begin
        eb     = 1'b1;
        tb.cls = CLS_PUNCT;
      end
    end

    // end of line flushes whatever is still open
    ec = chars.end_of_line && (mode_next != MODE_IDLE);
    tc = flush_tok(mode_next, word_prefix_next, open_length_next, open_start_next);
    if (chars.end_of_line) begin
      mode_next          = MODE_IDLE;
      word_prefix_next   = '0;
      open_length_next   = '0;
      open_start_next    = '0;
      line_position_next = '0;
    end else if (line_position < POS_CAP) begin
      line_position_next = line_position + POS_W'(1);
    end
  end

  // pack the emitted tokens in order, mark the last one
  always_comb begin
    push_data.two  = 1'b0;
    push_data.tok0 = tc;
    push_data.tok1 = tc;
    if (ea) begin
      push_data.tok0 = ta;
      push_data.tok1 = eb ? tb : tc;
      push_data.two  = eb || ec;
    end else if (eb) begin
      push_data.tok0 = tb;
      push_data.two  = ec;
    end
    if (push_data.two) push_data.tok1.last = 1'b1;
    else push_data.tok0.last = 1'b1;
    push = accept && (ea || eb || ec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      word_prefix   <= '0;
      open_length   <= '0;
      open_start    <= '0;
      line_position <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      word_prefix   <= word_prefix_next;
      open_length   <= open_length_next;
      open_start    <= open_start_next;
      line_position <= line_position_next;
    end
  end

`ifndef SYNTHESIS
  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_LESS || mode == MODE_GREATER) |-> (open_length == LEN_W'(1)))
    else $error("pending operator with length other than one");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (open_length == '0 && word_prefix == '0))
    else $error("idle lexer holds token data");
`endif

endmodule

>>> hdl/slx_queue.sv
`timescale 1ns / 1ps
// Short queue of token bundles between classifier and emitter.
module slx_queue import slx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  bundle_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");
`endif

endmodule

>>> hdl/slx_back.sv
`timescale 1ns / 1ps
// Emitter: splits queued bundles into single tokens behind an output register.
module slx_back import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  bundle_t    head,
  output logic       pop,
  slx_token_if.source tokens
);

  logic   idx;
  logic   out_valid;
  token_t out_tok;
  token_t cur_tok;
  logic   load;

  assign cur_tok = idx ? head.tok1 : head.tok0;
  assign load    = head_valid && (!out_valid || tokens.ready);
  assign pop     = load && (idx || !head.two);

  always_ff @(posedge clk) begin
    if (load) out_tok <= cur_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= !idx && head.two;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tokens.valid         = out_valid;
  assign tokens.token_class   = out_tok.cls;
  assign tokens.keyword_index = out_tok.kw;
  assign tokens.symbol_char   = out_tok.sym;
  assign tokens.doubled       = out_tok.dbl;
  assign tokens.token_start   = out_tok.start;
  assign tokens.token_length  = out_tok.len;
  assign tokens.last_of_run   = out_tok.last;

`ifndef SYNTHESIS
  a_second_half: assert property (@(posedge clk) disable iff (rst)
    idx |-> (head_valid && head.two))
    else $error("second token selected without a two-token bundle");
`endif

endmodule

>>> hdl/streaming_token_lexer.sv
`timescale 1ns / 1ps
// Top level of the streaming token lexer: classifier, bundle queue and emitter.
//
//   channel  dir  handshake     payload
//   chars    in   valid/ready   char_code[7:0], end_of_line
//   tokens   out  valid/ready   token_class, keyword_index, symbol_char, doubled,
//                               token_start, token_length, last_of_run
//
// The classifier takes one character per cycle whenever the four-entry bundle queue
// has room; a character's tokens (zero, one or two) are written into the queue at the
// edge that takes the character, and the first of them then passes through the
// emitter's output register before it is offered on tokens.
// The emitter sends one token per cycle through its output register while tokens is
// ready, so a queued bundle of two tokens goes out one token after the other; the
// output port sets the token rate. A stall on tokens fills the queue and then drops
// chars.ready; chars stay taken while older tokens wait. Reset (rst, synchronous)
// empties the queue and clears the open token and the line position.
module streaming_token_lexer import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  slx_char_if.sink    chars,
  slx_token_if.source tokens
);

  logic    push, q_full, pop, head_valid;
  bundle_t push_data, head;

  // character classification and token state
  slx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the two sides; one bundle per character that produced tokens
  slx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // serializes bundles onto the token request channel
  slx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule

>>> tb/tb_streaming_token_lexer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming token lexer: directed lines and random text.
module tb_streaming_token_lexer;
  import slx_pkg::*;

  // Shadow lexer plus the queue of tokens it says the block owes us.
  // take_char() runs on every accepted character request, check_token() on every
  // token request the block hands out.
  class token_checker;
    lex_mode_t        mode;
    logic [WORD_W-1:0] prefix;
    logic [LEN_W-1:0]  open_len;
    logic [POS_W-1:0]  open_start;
    logic [POS_W-1:0]  line_pos;
    token_t            owed_tokens[$];
    int unsigned       errors;

    function new();
      mode       = MODE_IDLE;
      prefix     = '0;
      open_len   = '0;
      open_start = '0;
      line_pos   = '0;
      errors     = 0;
    endfunction

    function int unsigned owed_count();
      return owed_tokens.size();
    endfunction

    function bit alpha(logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit numeric(logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void add_token(tok_class_t cls, kw_t kw, logic [CHAR_W-1:0] sym, logic dbl,
                            logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
      token_t t;
      t.cls   = cls;
      t.kw    = kw;
      t.sym   = sym;
      t.dbl   = dbl;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      owed_tokens.push_back(t);
    endfunction

    // append a character to the open word; only the first four are kept
    function void grow(logic [CHAR_W-1:0] c);
      if (open_len < 4) prefix |= WORD_W'(c) << (8 * open_len);
      if (open_len < LEN_CAP) open_len++;
    endfunction

    function void close_open();
      kw_t kw;
      kw = KW_NONE;
      case (mode)
        MODE_IDENT: begin
          if (open_len == 4 && prefix == WORD_COUT) kw = KW_COUT;
          else if (open_len == 3 && prefix == WORD_CIN) kw = KW_CIN;
          else if (open_len == 4 && prefix == WORD_ENDL) kw = KW_ENDL;
          add_token((kw == KW_NONE) ? CLS_IDENT : CLS_KEYWORD, kw, '0, 1'b0, open_start,
                    open_len);
        end
        MODE_NUMBER:  add_token(CLS_NUMBER, KW_NONE, '0, 1'b0, open_start, open_len);
        MODE_LESS:    add_token(CLS_OPER, KW_NONE, CH_LT, 1'b0, open_start, LEN_W'(1));
        MODE_GREATER: add_token(CLS_OPER, KW_NONE, CH_GT, 1'b0, open_start, LEN_W'(1));
        default: ;
      endcase
      mode     = MODE_IDLE;
      prefix   = '0;
      open_len = '0;
    endfunction

    function void take_char(logic [CHAR_W-1:0] c, logic eol);
      int unsigned      prior;
      bit               taken;
      logic [POS_W-1:0] pos;
      logic [CHAR_W-1:0] held;
      prior = owed_tokens.size();
      pos   = line_pos;
      taken = 1'b0;
      case (mode)
        MODE_IDENT: begin
          if (alpha(c) || numeric(c)) begin
            grow(c);
            taken = 1'b1;
          end else close_open();
        end
        MODE_NUMBER: begin
          if (numeric(c)) begin
            grow(c);
            taken = 1'b1;
          end else close_open();
        end
        MODE_LESS, MODE_GREATER: begin
          held = (mode == MODE_LESS) ? CH_LT : CH_GT;
          if (c == held) begin
            add_token(CLS_OPER, KW_NONE, held, 1'b1, open_start, LEN_W'(2));
            mode     = MODE_IDLE;
            prefix   = '0;
            open_len = '0;
            taken    = 1'b1;
          end else close_open();
        end
        default: mode = MODE_IDLE;
      endcase

      if (!taken) begin
        if (alpha(c) || numeric(c)) begin
          mode       = alpha(c) ? MODE_IDENT : MODE_NUMBER;
          open_start = pos;
          prefix     = '0;
          open_len   = '0;
          grow(c);
        end else if (c == CH_LT || c == CH_GT) begin
          mode       = (c == CH_LT) ? MODE_LESS : MODE_GREATER;
          open_start = pos;
          prefix     = '0;
          open_len   = LEN_W'(1);
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
          add_token(CLS_OPER, KW_NONE, c, 1'b0, pos, LEN_W'(1));
        end else if (c inside {CH_SEMI, CH_COLON, CH_LBRACE, CH_RBRACE}) begin
          add_token(CLS_PUNCT, KW_NONE, c, 1'b0, pos, LEN_W'(1));
        end
      end

      if (eol) begin
        close_open();
        line_pos   = '0;
        open_start = '0;
      end else if (line_pos < POS_CAP) begin
        line_pos++;
      end

      if (owed_tokens.size() > prior) owed_tokens[owed_tokens.size() - 1].last = 1'b1;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (owed_tokens.size() == 0) begin
        $error("token with nothing owed: class %0d start %0d length %0d",
               got.cls, got.start, got.len);
        errors++;
        return;
      end
      want = owed_tokens.pop_front();
      compare("token_class", want.cls, got.cls);
      compare("keyword_index", want.kw, got.kw);
      compare("symbol_char", want.sym, got.sym);
      compare("doubled", want.dbl, got.dbl);
      compare("token_start", want.start, got.start);
      compare("token_length", want.len, got.len);
      compare("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  slx_char_if  chars ();
  slx_token_if tokens ();

  streaming_token_lexer DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  token_checker lex_sb = new();

  // characters of the line being built, sent with end_of_line on the last one
  logic [CHAR_W-1:0] line_chars[$];
  int unsigned       sent_chars;
  // no_idle: both sides run flat out; hold_request: receiver stalls for a long stretch
  bit                no_idle;
  bit                hold_request;
  // the long receiver hold has been run
  bit                hold_done;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run, even with every stall at its maximum
  // and the long hold.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character driver. A fresh random gap is drawn per request; with no gap valid simply
  // stays high, so there is only ever one NBA per signal per step.
  // The shadow lexer sees the character at the edge where it was taken.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eol);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid       <= 1'b1;
    chars.char_code   <= c;
    chars.end_of_line <= eol;
    do @(posedge clk); while (!chars.ready);
    lex_sb.take_char(c, eol);
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
    sent_chars += line_chars.size();
    line_chars.delete();
  endtask

  // Drop valid and wait for every owed token; the wait always passes a clock edge, so the
  // next request never collides with the valid drop in the same step.
  task automatic settle();
    chars.valid <= 1'b0;
    do @(posedge clk); while (lex_sb.owed_count() != 0);
  endtask

  function automatic logic [CHAR_W-1:0] rand_letter();
    return $urandom_range(0, 1) ? CHAR_W'("a" + $urandom_range(0, 25))
                                : CHAR_W'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'("0" + $urandom_range(0, 9));
  endfunction

  task automatic add_text(input string s);
    foreach (s[i]) line_chars.push_back(s[i]);
  endtask

  // identifier: a letter, then letters or digits
  task automatic add_ident(input int len);
    line_chars.push_back(rand_letter());
    repeat (len - 1) line_chars.push_back($urandom_range(0, 2) == 0 ? rand_digit()
                                                                     : rand_letter());
  endtask

  // One random line: mostly well-formed words (keywords, near misses, identifiers,
  // numbers, operator runs, punctuation) with random separators, some raw noise.
  // A separator after the last word means end_of_line often lands on a skipped char.
  task automatic compose_line();
    int words;
    words = $urandom_range(1, 8);
    repeat (words) begin
      case ($urandom_range(0, 11))
        0: add_text("cout");
        1: add_text("cin");
        2: add_text("endl");
        3: begin
          // almost-keywords: wrong length or wrong case must stay identifiers
          case ($urandom_range(0, 5))
            0: add_text("count");
            1: add_text("ci");
            2: add_text("Cout");
            3: add_text("endl9");
            4: add_text("cinx");
            default: add_text("CIN");
          endcase
        end
        4: add_ident($urandom_range(1, 6));
        5: repeat ($urandom_range(1, 5)) line_chars.push_back(rand_digit());
        6: begin
          case ($urandom_range(0, 6))
            0: add_text("<<");
            1: add_text(">>");
            2: add_text("<<<");
            3: add_text(">>>");
            4: add_text("<");
            5: add_text(">");
            default: add_text("<>");
          endcase
        end
        7: begin
          case ($urandom_range(0, 3))
            0: line_chars.push_back(CH_PLUS);
            1: line_chars.push_back(CH_MINUS);
            2: line_chars.push_back(CH_STAR);
            default: line_chars.push_back(CH_SLASH);
          endcase
        end
        8: begin
          case ($urandom_range(0, 3))
            0: line_chars.push_back(CH_SEMI);
            1: line_chars.push_back(CH_COLON);
            2: line_chars.push_back(CH_LBRACE);
            default: line_chars.push_back(CH_RBRACE);
          endcase
        end
        9: begin
          // digits running straight into letters
          repeat ($urandom_range(1, 3)) line_chars.push_back(rand_digit());
          add_ident($urandom_range(1, 4));
        end
        10: line_chars.push_back(CHAR_W'($urandom_range(0, 255)));
        default: add_ident($urandom_range(5, 12));
      endcase
      case ($urandom_range(0, 4))
        2: line_chars.push_back(" ");
        3: line_chars.push_back(8'h09);
        4: line_chars.push_back(CHAR_W'($urandom_range(0, 255)));
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token receiver: per request draws a random stall, or the long hold when
  // asked, then holds ready high until a token goes through.
  // ---------------------------------------------------------------------------
  initial begin : token_sink
    int stall;
    tokens.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        tokens.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tokens.ready <= 1'b1;
      do @(posedge clk); while (!tokens.valid);
    end
  end

  // Token monitor: values read at the edge are the pre-edge ones, so no race with the DUT.
  always @(posedge clk) begin : token_watch
    token_t got;
    if (!rst && tokens.valid && tokens.ready) begin
      got.cls   = tok_class_t'(tokens.token_class);
      got.kw    = kw_t'(tokens.keyword_index);
      got.sym   = tokens.symbol_char;
      got.dbl   = tokens.doubled;
      got.start = tokens.token_start;
      got.len   = tokens.token_length;
      got.last  = tokens.last_of_run;
      lex_sb.check_token(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sent_chars   = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    rst               <= 1'b1;
    chars.valid       <= 1'b0;
    chars.char_code   <= '0;
    chars.end_of_line <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines.
    // keywords around a doubled '<', punctuation closing the line
    add_text("cout<<endl;");
    send_line();
    // cin, '>>', a number cut by a letter, then '<<<' -> '<<' plus a '<' that the
    // line end has to flush
    add_text("cin>>7x<<<");
    send_line();
    // every single operator, all punctuation but ';', an undoubled '<' and '>' each
    // followed by something else, line end riding on a high non-ASCII code that is skipped
    add_text("+-*/:{}<a>");
    line_chars.push_back(8'hFF);
    send_line();
    settle();

    // Random text. Part way through, the receiver sits out a long hold while the
    // sender keeps pushing one-token punctuation, so the queue fills and chars.ready
    // drops. Now and then the sender stops until everything owed has come back.
    sent_chars = 0;
    while (sent_chars < 800) begin
      if (!hold_done && sent_chars >= 400) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
        no_idle      = 1'b1;
        repeat (40) line_chars.push_back($urandom_range(0, 1) ? CH_SEMI : CH_RBRACE);
        send_line();
        no_idle = 1'b0;
        settle();
      end
      no_idle = ($urandom_range(0, 5) == 0);
      compose_line();
      send_line();
      if ($urandom_range(0, 14) == 0) settle();
    end
    no_idle = 1'b0;

    // drain, then wait TAIL_CYCLES for anything stray to show up
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lex_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
